### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the rtl, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

### hw/rtl/e2c_pkg.sv
// ----------------------------------------------------------------------------
// e2c_pkg
// types, constants and microcode rom for the epoch seconds to calendar block
// ----------------------------------------------------------------------------
package e2c_pkg;

  localparam int unsigned PC_W = 5;
  typedef logic [PC_W-1:0] pc_t;

  localparam logic [11:0] EPOCH_RESET = 12'd2001;

  // reciprocals for the divide-by-constant steps, estimate is floor or floor-1
  localparam logic [31:0] RECIP_60 = 32'd2290649224;  // floor(2^37 / 60)
  localparam logic [31:0] RECIP_24 = 32'd2863311530;  // floor(2^36 / 24)
  localparam logic [12:0] DIV100_MUL = 13'd5243;      // (y * 5243) >> 19 == y / 100

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_MUL,
    OP_QUO,
    OP_QD,
    OP_REM,
    OP_YINIT,
    OP_YMOD,
    OP_YEAR,
    OP_MON,
    OP_OUT
  } op_e;

  typedef enum logic [1:0] {
    DIV_SEC,
    DIV_MIN,
    DIV_HR
  } dsel_e;

  typedef struct packed {
    op_e   op;
    dsel_e sel;
    logic  last;
  } ctrl_t;

  function automatic logic [5:0] divisor(input dsel_e sel);
    logic [5:0] d;
    unique case (sel)
      DIV_HR:  d = 6'd24;
      default: d = 6'd60;
    endcase
    return d;
  endfunction

  function automatic logic [31:0] recip(input dsel_e sel);
    logic [31:0] r;
    unique case (sel)
      DIV_HR:  r = RECIP_24;
      default: r = RECIP_60;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] l;
    unique case (mon)
      4'd2:                      l = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   l = 5'd30;
      default:                   l = 5'd31;
    endcase
    return l;
  endfunction

  // the program: load, three constant divisions, year setup, year and month loops, output
  function automatic ctrl_t ucode(input pc_t pc);
    ctrl_t c;
    unique case (pc)
      5'd0:    c = '{op: OP_LOAD,  sel: DIV_SEC, last: 1'b0};
      5'd1:    c = '{op: OP_MUL,   sel: DIV_SEC, last: 1'b0};
      5'd2:    c = '{op: OP_QUO,   sel: DIV_SEC, last: 1'b0};
      5'd3:    c = '{op: OP_QD,    sel: DIV_SEC, last: 1'b0};
      5'd4:    c = '{op: OP_REM,   sel: DIV_SEC, last: 1'b0};
      5'd5:    c = '{op: OP_MUL,   sel: DIV_MIN, last: 1'b0};
      5'd6:    c = '{op: OP_QUO,   sel: DIV_MIN, last: 1'b0};
      5'd7:    c = '{op: OP_QD,    sel: DIV_MIN, last: 1'b0};
      5'd8:    c = '{op: OP_REM,   sel: DIV_MIN, last: 1'b0};
      5'd9:    c = '{op: OP_MUL,   sel: DIV_HR,  last: 1'b0};
      5'd10:   c = '{op: OP_QUO,   sel: DIV_HR,  last: 1'b0};
      5'd11:   c = '{op: OP_QD,    sel: DIV_HR,  last: 1'b0};
      5'd12:   c = '{op: OP_REM,   sel: DIV_HR,  last: 1'b0};
      5'd13:   c = '{op: OP_YINIT, sel: DIV_SEC, last: 1'b0};
      5'd14:   c = '{op: OP_YMOD,  sel: DIV_SEC, last: 1'b0};
      5'd15:   c = '{op: OP_YEAR,  sel: DIV_SEC, last: 1'b0};
      5'd16:   c = '{op: OP_MON,   sel: DIV_SEC, last: 1'b0};
      5'd17:   c = '{op: OP_OUT,   sel: DIV_SEC, last: 1'b1};
      default: c = '{op: OP_NOP,   sel: DIV_SEC, last: 1'b1};
    endcase
    return c;
  endfunction

endpackage

### hw/rtl/e2c_seq.sv
// ----------------------------------------------------------------------------
// e2c_seq
// step counter and microcode rom, a step repeats while the datapath holds it
// ----------------------------------------------------------------------------
module e2c_seq
  import e2c_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  hold_i,
  output ctrl_t ctrl_o,
  output pc_t   step_o
);

  pc_t pc_q, pc_d;

  assign ctrl_o = ucode(pc_q);
  assign step_o = pc_q;

  // hold is the conditional jump back to the same step
  always_comb begin
    priority if (hold_i) begin
      pc_d = pc_q;
    end else if (ctrl_o.last) begin
      pc_d = '0;
    end else begin
      pc_d = pc_q + pc_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

### hw/rtl/epoch_seconds_to_calendar_core.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_core
// converts seconds since an epoch year into gregorian date and time of day
// ----------------------------------------------------------------------------
// usage
//  - slave stream: one beat carries seconds since jan 1 00:00:00 of epoch_year
//  - master stream: one beat carries year, month, day, hour, minute, second
//  - cfg channel writes epoch_year (always ready); write only while idle
//  - a microcoded sequencer runs 18 steps per beat: three divisions by a
//    constant (4 steps each, one 31x32 multiplier shared), year setup, then
//    a year loop that takes off whole years and a month loop for whole months
//  - one beat is in work at a time; the next beat can be accepted from the
//    cycle after the result is loaded into the output register
//  - the result sits in an output register, so the next beat is accepted
//    while the previous result waits; a stalled receiver only holds the
//    sequencer at its last step once the new result is ready
//  - reset clears the sequencer and the output valid, epoch_year goes to 2001
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module epoch_seconds_to_calendar_core
  import e2c_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [11:0] cfg_data_i,     // epoch_year
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [30:0] seconds, [31] zero
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // year, month, day, hour, minute, second, pad
);

  ctrl_t ctrl;
  pc_t   step;
  logic  hold;

  e2c_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .hold_i (hold),
    .ctrl_o (ctrl),
    .step_o (step)
  );

  // configuration register
  logic [11:0] epoch_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_q <= EPOCH_RESET;
    end else if (cfg_valid_i) begin
      epoch_q <= cfg_data_i;
    end
  end

  // datapath registers
  logic [30:0] a_q;        // working value: seconds, then minutes, hours, days
  logic [62:0] prod_q;     // reciprocal product
  logic [25:0] q_q;        // quotient estimate
  logic [30:0] qd_q;       // quotient times divisor
  logic [5:0]  sec_q, min_q;
  logic [4:0]  hr_q;
  logic [12:0] y_q;        // one bit wider than the field, whose bits [11:0] are sent out
  logic [5:0]  hq_q;       // epoch year / 100
  logic [6:0]  m100_q;     // year mod 100
  logic [8:0]  m400_q;     // year mod 400
  logic [3:0]  mon_q;
  logic        out_valid_q;
  logic [37:0] out_data_q;

  // divide step pieces
  logic [5:0]  div;
  logic [31:0] qd_full;
  logic [30:0] rem;
  logic        rem_ge;
  logic [6:0]  fld;
  logic [30:0] q_next;

  assign div     = divisor(ctrl.sel);
  assign qd_full = 32'(q_q) * 32'(div);
  assign rem     = a_q - qd_q;
  assign rem_ge  = rem >= 31'(div);
  assign fld     = rem_ge ? (rem[6:0] - 7'(div)) : rem[6:0];
  assign q_next  = 31'(q_q) + (rem_ge ? 31'd1 : 31'd0);

  // year setup pieces
  logic [24:0] hq_prod;
  logic [11:0] hq100;
  logic [6:0]  m100_init;
  assign hq_prod   = 25'(epoch_q) * 25'(DIV100_MUL);
  assign hq100     = 12'(hq_q) * 12'd100;
  assign m100_init = 7'(y_q[11:0] - hq100);

  // calendar loop pieces
  logic       leap;
  logic [8:0] ylen;
  logic [4:0] mlen;
  logic       ytake, mtake;
  assign leap  = ((y_q[1:0] == 2'd0) && (m100_q != 7'd0)) || (m400_q == 9'd0);
  assign ylen  = leap ? 9'd366 : 9'd365;
  assign mlen  = month_len(mon_q, leap);
  assign ytake = a_q >= 31'(ylen);
  assign mtake = (mon_q < 4'd12) && (a_q >= 31'(mlen));

  logic out_busy;
  assign out_busy = out_valid_q && !m_axis_tready;

  always_comb begin
    unique case (ctrl.op)
      OP_LOAD: hold = !s_axis_tvalid;
      OP_YEAR: hold = ytake;
      OP_MON:  hold = mtake;
      OP_OUT:  hold = out_busy;
      default: hold = 1'b0;
    endcase
  end

  assign s_axis_tready = (ctrl.op == OP_LOAD);

  always_ff @(posedge clk_i) begin
    unique case (ctrl.op)
      OP_LOAD: begin
        a_q   <= s_axis_tdata[30:0];
        y_q   <= {1'b0, epoch_q};
        mon_q <= 4'd1;
      end
      OP_MUL: begin
        prod_q <= 63'(a_q) * 63'(recip(ctrl.sel));
      end
      OP_QUO: begin
        q_q <= (ctrl.sel == DIV_HR) ? prod_q[61:36] : prod_q[62:37];
      end
      OP_QD: begin
        qd_q <= qd_full[30:0];
      end
      OP_REM: begin
        a_q <= q_next;
        unique case (ctrl.sel)
          DIV_SEC: sec_q <= fld[5:0];
          DIV_MIN: min_q <= fld[5:0];
          default: hr_q  <= fld[4:0];
        endcase
      end
      OP_YINIT: begin
        hq_q <= hq_prod[24:19];
      end
      OP_YMOD: begin
        m100_q <= m100_init;
        m400_q <= 9'(hq_q[1:0]) * 9'd100 + 9'(m100_init);
      end
      OP_YEAR: begin
        if (ytake) begin
          a_q    <= a_q - 31'(ylen);
          y_q    <= y_q + 13'd1;
          m100_q <= (m100_q == 7'd99)  ? 7'd0 : m100_q + 7'd1;
          m400_q <= (m400_q == 9'd399) ? 9'd0 : m400_q + 9'd1;
        end
      end
      OP_MON: begin
        if (mtake) begin
          a_q   <= a_q - 31'(mlen);
          mon_q <= mon_q + 4'd1;
        end
      end
      OP_OUT: begin
        if (!out_busy) begin
          out_data_q <= {sec_q, min_q, hr_q, a_q[4:0] + 5'd1, mon_q, y_q[11:0]};
        end
      end
      default: begin
      end
    endcase
  end

  // output register, can be refilled in the cycle its old beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((ctrl.op == OP_OUT) && !out_busy) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_data_q};

  // checks
  `ASSERT_CLK(a_accept_starts_program,
    (s_axis_tvalid && s_axis_tready) |=> (step == pc_t'(1)),
    "accepted beat did not start the division steps")
  `ASSERT_CLK(a_month_day_range,
    m_axis_tvalid |-> ((out_data_q[15:12] >= 4'd1) && (out_data_q[15:12] <= 4'd12)
                       && (out_data_q[20:16] != 5'd0)),
    "month or day out of range")
  `ASSERT_CLK(a_time_range,
    m_axis_tvalid |-> ((out_data_q[25:21] < 5'd24) && (out_data_q[31:26] < 6'd60)
                       && (out_data_q[37:32] < 6'd60)),
    "time of day out of range")
  `ASSERT_NEVER(a_month_past_dec,
    (ctrl.op == OP_MON) && (mon_q > 4'd12),
    "month loop ran past december")

endmodule
